[hw/rtl/smt_pkg.sv]
// smt_pkg: shared types, codes and defaults for the set membership table
// used by smt_core and set_membership_table; no dependencies
package smt_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OP,
    ST_SHIFT,
    ST_READ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                hit;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

[hw/rtl/smt_mem.sv]
// smt_mem: entry store, one write port and one registered read port
// depends on nothing
module smt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/smt_core.sv]
// smt_core: sequencer with the shared compare unit; scans, inserts, shifts, reads
// depends on smt_pkg and smt_mem
module smt_core #(
  parameter int CAPACITY = smt_pkg::CAPACITY_DEF,
  parameter int SW       = smt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smt_pkg::KIND_W-1:0]    in_kind,
  input  logic [SW-1:0]                 in_value,
  input  logic [smt_pkg::INDEX_W-1:0]   in_index,
  input  logic                          res_free,
  output logic                          res_valid,
  output smt_pkg::res_t                 res
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > smt_pkg::INDEX_W) ? CW : smt_pkg::INDEX_W;
  localparam int OW  = (CW > smt_pkg::COUNT_W) ? CW : smt_pkg::COUNT_W;

  smt_pkg::state_t state_r, state_nxt;

  logic [smt_pkg::KIND_W-1:0]   kind_r;
  logic [SW-1:0]                val_r;
  logic [XW-1:0]                idx_r;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                addr_r, addr_nxt;
  logic                         pend_r, pend_nxt;
  logic [AW-1:0]                pos_r, pos_nxt;
  logic                         hit_r, hit_nxt;
  logic [SW-1:0]                rd_r, rd_nxt;
  logic [smt_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;

  logic          accept;
  logic          match;
  logic          more;
  logic          idx_ok;
  logic [OW-1:0] cnt_ext;

  smt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (SW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept = in_valid && (state_r == smt_pkg::ST_IDLE);
  assign match  = pend_r && (mem_rdata == val_r);
  assign more   = addr_r < cnt_r;
  assign idx_ok = idx_r < XW'(cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = smt_pkg::ST_SCAN;
        end
      end
      smt_pkg::ST_SCAN: begin
        if (match || !more) begin
          state_nxt = smt_pkg::ST_OP;
        end
      end
      smt_pkg::ST_OP: begin
        state_nxt = smt_pkg::ST_FIN;
        if (kind_r == smt_pkg::KIND_DELETE && hit_r) begin
          state_nxt = smt_pkg::ST_SHIFT;
        end else if (kind_r == smt_pkg::KIND_READ && idx_ok) begin
          state_nxt = smt_pkg::ST_READ;
        end
      end
      smt_pkg::ST_SHIFT: begin
        if (!more) begin
          state_nxt = smt_pkg::ST_FIN;
        end
      end
      smt_pkg::ST_READ: begin
        state_nxt = smt_pkg::ST_FIN;
      end
      smt_pkg::ST_FIN: begin
        if (res_free) begin
          state_nxt = smt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smt_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt    = cnt_r;
    addr_nxt   = addr_r;
    pend_nxt   = 1'b0;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = addr_r[AW-1:0];
    res_valid  = 1'b0;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        addr_nxt   = '0;
        hit_nxt    = 1'b0;
        rd_nxt     = '0;
        status_nxt = smt_pkg::STATUS_OK;
      end
      smt_pkg::ST_SCAN: begin
        if (match) begin
          hit_nxt = 1'b1;
          pos_nxt = AW'(addr_r - 1'b1);
        end else if (more) begin
          addr_nxt = addr_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end
      smt_pkg::ST_OP: begin
        mem_raddr = idx_r[AW-1:0];
        unique case (kind_r)
          smt_pkg::KIND_CLEAR: begin
            cnt_nxt = '0;
          end
          smt_pkg::KIND_INSERT: begin
            if (!hit_r) begin
              if (cnt_r >= CW'(CAPACITY)) begin
                status_nxt = smt_pkg::STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = val_r;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
          end
          smt_pkg::KIND_DELETE: begin
            addr_nxt = CW'(pos_r) + 1'b1;
          end
          smt_pkg::KIND_READ: begin
            if (!idx_ok) begin
              status_nxt = smt_pkg::STATUS_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      smt_pkg::ST_SHIFT: begin
        if (pend_r) begin
          mem_we  = 1'b1;
          pos_nxt = pos_r + 1'b1;
        end
        if (more) begin
          addr_nxt = addr_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      smt_pkg::ST_READ: begin
        rd_nxt = mem_rdata;
      end
      smt_pkg::ST_FIN: begin
        res_valid = res_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smt_pkg::ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      val_r  <= in_value;
      idx_r  <= XW'(in_index);
    end
    addr_r   <= addr_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
  end

  assign in_stall = (state_r != smt_pkg::ST_IDLE);
  assign cnt_ext  = OW'(cnt_r);

  always_comb begin
    res.hit        = hit_r;
    res.count      = cnt_ext[smt_pkg::COUNT_W-1:0];
    res.is_full    = (cnt_r == CW'(CAPACITY));
    res.is_empty   = (cnt_r == '0);
    res.read_value = smt_pkg::VALUE_W'(rd_r);
    res.status     = status_r;
  end

endmodule

[hw/rtl/set_membership_table.sv]
// set_membership_table: packed ordered set with a count, one result per beat
// depends on smt_pkg, smt_core and smt_mem
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/in_stall   kind, value, index
//   out_     output     out_valid/out_stall hit, count, is_full, is_empty,
//                                           read_value, status
//
// each op scans the entries one per cycle through the single read port;
// a miss scans every entry, a hit ends the scan at its position; a read adds the ST_READ state
// a delete that hits adds a shift of the entries behind it, one entry moved per cycle
// one op in flight; the next beat is taken once the result sits in the output register
// a stalled result holds while the following op runs; no clearing pass after reset
module set_membership_table #(
  parameter int CAPACITY    = smt_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [smt_pkg::KIND_W-1:0]      in_kind,
  input  logic signed [smt_pkg::VALUE_W-1:0] in_value,
  input  logic [smt_pkg::INDEX_W-1:0]     in_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [smt_pkg::COUNT_W-1:0]     out_count,
  output logic                            out_is_full,
  output logic                            out_is_empty,
  output logic signed [smt_pkg::VALUE_W-1:0] out_read_value,
  output logic [smt_pkg::STATUS_W-1:0]    out_status
);

  localparam int SW = (VALUE_WIDTH < smt_pkg::VALUE_W) ? VALUE_WIDTH : smt_pkg::VALUE_W;

  logic          res_free;
  logic          res_valid;
  smt_pkg::res_t res;
  smt_pkg::res_t out_r;
  logic          out_valid_r;

  smt_core #(
    .CAPACITY (CAPACITY),
    .SW       (SW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_value  (in_value[SW-1:0]),
    .in_index  (in_index),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_r.hit;
  assign out_count      = out_r.count;
  assign out_is_full    = out_r.is_full;
  assign out_is_empty   = out_r.is_empty;
  assign out_read_value = out_r.read_value;
  assign out_status     = out_r.status;

endmodule
